[design/lcr_pkg.sv]
// Shared types, widths and constants of the four-point Lagrange resampler.
// Used by the stream interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcr_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 20;

    // Defaults of the top-level parameters.
    localparam int FRAC_BITS_DEF  = 16;
    localparam int INDEX_BITS_DEF = 20;
    localparam int MAX_OUT_DEF    = 8;

    // Reset value of the rate step register (one source sample per output).
    localparam logic [STEP_W-1:0] RATE_STEP_RST = 20'd65536;

    // Configuration port.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic [APB_AW-3:0] REG_RATE_STEP = '0;

    // Datapath widths. They follow from the 16-bit sample range, not from the
    // fraction width: polynomial terms stay within 22 signed bits and the
    // scaled result magnitude stays below 2^21.
    localparam int OPW = 22;
    localparam int U_W = 22;
    localparam int M_W = 21;
    localparam int Q_W = 19;

    // Division by six as a multiply by a rounded-up reciprocal. The estimate
    // is at most one too large and is corrected afterwards.
    localparam int DIV6_K = M_W + 3;
    localparam int R_W    = 22;
    localparam logic [R_W-1:0] DIV6_R = R_W'(((1 << DIV6_K) + 5) / 6);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SETUP,
        OP_MUL_A,
        OP_MUL_H,
        OP_MUL_G,
        OP_SCALE,
        OP_RECIP,
        OP_FINAL
    } t_dp_op;

    typedef struct packed {
        logic   load;
        logic   emit;
        logic   finish;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic more;
        logic pend;
        logic out_free;
        logic lin;
    } t_dp_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_A,
        ST_MUL_H,
        ST_MUL_G,
        ST_SCALE,
        ST_RECIP,
        ST_FINAL
    } t_state;

endpackage

`default_nettype wire

[design/lcr_stream_if.sv]
// Valid/ready stream interfaces for source samples and resampled results.
// Depends on lcr_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

interface lcr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [lcr_pkg::SAMPLE_W-1:0] sample_in;
    logic                                clip_end;

    modport source (output valid, output sample_in, output clip_end, input ready);
    modport sink   (input valid, input sample_in, input clip_end, output ready);
endinterface

interface lcr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lcr_pkg::SAMPLE_W-1:0] sample_out;
    logic                                last_of_run;
    logic                                clip_done;

    modport source (output valid, output sample_out, output last_of_run,
                    output clip_done, input ready);
    modport sink   (input valid, input sample_out, input last_of_run,
                    input clip_done, output ready);
endinterface

`default_nettype wire

[design/lcr_datapath.sv]
// Datapath of the resampler: sample window, position tracking, one shared
// multiplier for the Horner steps, a reciprocal multiply for the divide-by-six,
// and the output register. Depends on lcr_pkg; driven by lcr_ctrl through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module lcr_datapath #(
    parameter int FRAC_BITS      = lcr_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS     = lcr_pkg::INDEX_BITS_DEF,
    parameter int MAX_OUT_PER_IN = lcr_pkg::MAX_OUT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lcr_pkg::t_dp_cmd                    i_cmd,
    output lcr_pkg::t_dp_status                      o_status,
    input  wire logic [lcr_pkg::STEP_W-1:0]          i_rate_step,
    input  wire logic signed [lcr_pkg::SAMPLE_W-1:0] i_sample_in,
    input  wire logic                                i_clip_end,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic signed [lcr_pkg::SAMPLE_W-1:0]      o_sample_out,
    output logic                                     o_last_of_run,
    output logic                                     o_clip_done
);

    localparam int SW     = lcr_pkg::SAMPLE_W;
    localparam int OPW    = lcr_pkg::OPW;
    localparam int U_W    = lcr_pkg::U_W;
    localparam int M_W    = lcr_pkg::M_W;
    localparam int Q_W    = lcr_pkg::Q_W;
    localparam int POS_W  = INDEX_BITS + FRAC_BITS;
    localparam int CNT_W  = $clog2(MAX_OUT_PER_IN + 1);
    localparam int TW     = FRAC_BITS + 1;
    localparam int PROD_W = OPW + TW;
    localparam int NUM_W  = PROD_W + 1;

    localparam logic signed [POS_W-1:0] ONE_POS =
        {{(POS_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [U_W-1:0] SAT_HI = {{(U_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [U_W-1:0] SAT_LO = {{(U_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

    // Sample at 'back' places before the newest one; clamps at both ends.
    function automatic logic signed [SW-1:0] pick_tap(
        input logic signed [3:0]    back,
        input logic signed [SW-1:0] w0,
        input logic signed [SW-1:0] w1,
        input logic signed [SW-1:0] w2,
        input logic signed [SW-1:0] w3
    );
        logic signed [SW-1:0] v;
        if (back < 4'sd0) begin
            v = w3;
        end else begin
            case (back)
                4'sd0:   v = w3;
                4'sd1:   v = w2;
                4'sd2:   v = w1;
                default: v = w0;
            endcase
        end
        return v;
    endfunction

    // Control and state registers.
    logic signed [SW-1:0] r_win0, r_win1, r_win2, r_win3;
    logic [POS_W-1:0]      r_pos;
    logic [INDEX_BITS-1:0] r_idx;
    logic                  r_last;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_pend;
    logic                  r_out_valid;

    // Payload registers.
    logic signed [OPW-1:0]    r_op_a, r_a2, r_a1;
    logic signed [SW-1:0]     r_b;
    logic                     r_lin;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [U_W-1:0]    r_u;
    logic [Q_W-1:0]           r_q;
    logic signed [SW-1:0]     r_res;
    logic signed [SW-1:0]     r_out_sample;
    logic                     r_out_lor;
    logic                     r_out_cd;

    // Position bookkeeping.
    logic [FRAC_BITS-1:0]     pos_frac;
    logic [INDEX_BITS-1:0]    pos_int;
    logic [POS_W-1:0]         idx_pos;
    logic signed [POS_W-1:0]  idx_gap;
    logic signed [POS_W-1:0]  thr;
    logic                     dist_gt_thr;
    logic                     dist_gt_one;
    logic                     more;
    logic                     out_free;

    // Tap selection and coefficients.
    logic [INDEX_BITS-1:0]    off;
    logic [2:0]               off_c;
    logic signed [3:0]        ob;
    logic signed [SW-1:0]     tap_a, tap_b, tap_c, tap_d;
    logic signed [OPW-1:0]    ta, tb, tc, td, tb3, tc3, s2;
    logic signed [OPW-1:0]    a3, a2, a1, op_a;
    logic                     lin_now;

    // Multiplier and scaling.
    logic signed [PROD_W-1:0] prod_sh;
    logic                     prod_rnd;
    logic signed [OPW-1:0]    prod_tr;
    logic signed [OPW-1:0]    mul_op;
    logic signed [TW-1:0]     mul_t;
    logic signed [PROD_W-1:0] mul_out;
    logic signed [NUM_W-1:0]  b_ext, base, num, num_sh;
    logic                     num_rnd;
    logic signed [U_W-1:0]    u_next;
    logic [U_W-1:0]           u_abs;
    logic [M_W-1:0]           u_mag;
    logic [M_W+lcr_pkg::R_W-1:0] recip_prod;
    logic [Q_W+2:0]           q6;
    logic [Q_W-1:0]           q_fix;
    logic signed [U_W-1:0]    q_ext, quo, val;
    logic signed [SW-1:0]     sat_val;

    always_comb begin
        pos_frac    = r_pos[FRAC_BITS-1:0];
        pos_int     = r_pos[POS_W-1:FRAC_BITS];
        idx_pos     = {r_idx, {FRAC_BITS{1'b0}}};
        idx_gap     = signed'(idx_pos - r_pos);
        // A clip-end step drains every position below the clip length.
        thr         = r_last ? -ONE_POS : ONE_POS;
        dist_gt_thr = idx_gap > thr;
        dist_gt_one = idx_gap > ONE_POS;
        more        = (r_cnt < CNT_W'(MAX_OUT_PER_IN)) && dist_gt_thr;
        out_free    = !r_out_valid || i_out_ready;
    end

    always_comb begin
        // Distance in whole samples from the output position to the newest
        // sample; never negative while outputs are being produced.
        off     = r_idx - pos_int;
        off_c   = (|off[INDEX_BITS-1:2]) ? 3'd4 : off[2:0];
        ob      = signed'({1'b0, off_c});
        tap_a   = pick_tap(ob + 4'sd1, r_win0, r_win1, r_win2, r_win3);
        tap_b   = pick_tap(ob,         r_win0, r_win1, r_win2, r_win3);
        tap_c   = pick_tap(ob - 4'sd1, r_win0, r_win1, r_win2, r_win3);
        tap_d   = pick_tap(ob - 4'sd2, r_win0, r_win1, r_win2, r_win3);
        lin_now = !(|pos_int[INDEX_BITS-1:1]) || (off_c <= 3'd1);

        ta  = OPW'(tap_a);
        tb  = OPW'(tap_b);
        tc  = OPW'(tap_c);
        td  = OPW'(tap_d);
        tb3 = (tb <<< 1) + tb;
        tc3 = (tc <<< 1) + tc;
        s2  = ta + tc - (tb <<< 1);
        a3  = td - ta + tb3 - tc3;
        a2  = (s2 <<< 1) + s2;
        a1  = (tc3 <<< 1) - (ta <<< 1) - tb3 - td;
        op_a = lin_now ? (tc - tb) : a3;
    end

    always_comb begin
        // Truncate the last product toward zero after dropping the fraction.
        prod_sh  = r_prod >>> FRAC_BITS;
        prod_rnd = r_prod[PROD_W-1] && (|r_prod[FRAC_BITS-1:0]);
        prod_tr  = signed'(prod_sh[OPW-1:0] + {{(OPW-1){1'b0}}, prod_rnd});

        case (i_cmd.op)
            lcr_pkg::OP_MUL_H: mul_op = r_a2 + prod_tr;
            lcr_pkg::OP_MUL_G: mul_op = r_a1 + prod_tr;
            default:           mul_op = r_op_a;
        endcase
        mul_t   = signed'({1'b0, pos_frac});
        mul_out = mul_op * mul_t;

        b_ext   = NUM_W'(r_b);
        base    = r_lin ? b_ext : ((b_ext <<< 2) + (b_ext <<< 1));
        num     = (base <<< FRAC_BITS) + NUM_W'(r_prod);
        num_sh  = num >>> FRAC_BITS;
        num_rnd = num[NUM_W-1] && (|num[FRAC_BITS-1:0]);
        u_next  = signed'(num_sh[U_W-1:0] + {{(U_W-1){1'b0}}, num_rnd});

        u_abs      = r_u[U_W-1] ? -r_u : r_u;
        u_mag      = u_abs[M_W-1:0];
        recip_prod = u_mag * lcr_pkg::DIV6_R;

        q6    = ({3'b000, r_q} << 2) + ({3'b000, r_q} << 1);
        q_fix = (q6 > {{(Q_W+3-M_W){1'b0}}, u_mag}) ? (r_q - 1'b1) : r_q;
        q_ext = signed'({{(U_W-Q_W){1'b0}}, q_fix});
        quo   = r_u[U_W-1] ? -q_ext : q_ext;
        val   = r_lin ? r_u : quo;

        if (val > SAT_HI) begin
            sat_val = SAT_HI[SW-1:0];
        end else if (val < SAT_LO) begin
            sat_val = SAT_LO[SW-1:0];
        end else begin
            sat_val = val[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0      <= '0;
            r_win1      <= '0;
            r_win2      <= '0;
            r_win3      <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_last      <= 1'b0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_win0 <= r_win1;
                r_win1 <= r_win2;
                r_win2 <= r_win3;
                r_win3 <= i_sample_in;
                r_last <= i_clip_end;
                r_cnt  <= '0;
            end
            if (i_cmd.op == lcr_pkg::OP_FINAL) begin
                r_pos  <= r_pos + POS_W'(i_rate_step);
                r_cnt  <= r_cnt + 1'b1;
                r_pend <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_pos <= '0;
                    r_idx <= '0;
                end else begin
                    // Outputs dropped by the cap: restart at the next interval.
                    if (dist_gt_one) begin
                        r_pos <= idx_pos - ONE_POS;
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sample <= r_res;
            r_out_lor    <= !more;
            r_out_cd     <= !more && r_last;
        end
        case (i_cmd.op)
            lcr_pkg::OP_SETUP: begin
                r_op_a <= op_a;
                r_a2   <= a2;
                r_a1   <= a1;
                r_b    <= tap_b;
                r_lin  <= lin_now;
            end
            lcr_pkg::OP_MUL_A,
            lcr_pkg::OP_MUL_H,
            lcr_pkg::OP_MUL_G: begin
                r_prod <= mul_out;
            end
            lcr_pkg::OP_SCALE: begin
                r_u <= u_next;
            end
            lcr_pkg::OP_RECIP: begin
                r_q <= recip_prod[lcr_pkg::DIV6_K +: Q_W];
            end
            lcr_pkg::OP_FINAL: begin
                r_res <= sat_val;
            end
            default: begin
            end
        endcase
    end

    assign o_status.more     = more;
    assign o_status.pend     = r_pend;
    assign o_status.out_free = out_free;
    assign o_status.lin      = r_lin;

    assign o_out_valid   = r_out_valid;
    assign o_sample_out  = r_out_sample;
    assign o_last_of_run = r_out_lor;
    assign o_clip_done   = r_out_cd;

endmodule

`default_nettype wire

[design/lcr_ctrl.sv]
// Controller of the resampler: sequences input requests, the per-output
// evaluation steps and result hand-off. Depends on lcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcr_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire lcr_pkg::t_dp_status i_status,
    output lcr_pkg::t_dp_cmd         o_cmd
);

    lcr_pkg::t_state r_state;
    lcr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.emit    = 1'b0;
        o_cmd.finish  = 1'b0;
        o_cmd.op      = lcr_pkg::OP_NONE;

        unique case (r_state)
            lcr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lcr_pkg::ST_CHECK;
                end
            end
            lcr_pkg::ST_CHECK: begin
                // A finished result must leave before the next one is started,
                // since its last flag depends on whether another one follows.
                if (!i_status.pend || i_status.out_free) begin
                    o_cmd.emit = i_status.pend;
                    if (i_status.more) begin
                        o_cmd.op = lcr_pkg::OP_SETUP;
                        n_state  = lcr_pkg::ST_MUL_A;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = lcr_pkg::ST_IDLE;
                    end
                end
            end
            lcr_pkg::ST_MUL_A: begin
                o_cmd.op = lcr_pkg::OP_MUL_A;
                n_state  = i_status.lin ? lcr_pkg::ST_SCALE : lcr_pkg::ST_MUL_H;
            end
            lcr_pkg::ST_MUL_H: begin
                o_cmd.op = lcr_pkg::OP_MUL_H;
                n_state  = lcr_pkg::ST_MUL_G;
            end
            lcr_pkg::ST_MUL_G: begin
                o_cmd.op = lcr_pkg::OP_MUL_G;
                n_state  = lcr_pkg::ST_SCALE;
            end
            lcr_pkg::ST_SCALE: begin
                o_cmd.op = lcr_pkg::OP_SCALE;
                n_state  = i_status.lin ? lcr_pkg::ST_FINAL : lcr_pkg::ST_RECIP;
            end
            lcr_pkg::ST_RECIP: begin
                o_cmd.op = lcr_pkg::OP_RECIP;
                n_state  = lcr_pkg::ST_FINAL;
            end
            lcr_pkg::ST_FINAL: begin
                o_cmd.op = lcr_pkg::OP_FINAL;
                n_state  = lcr_pkg::ST_CHECK;
            end
            default: begin
                n_state = lcr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/lagrange_cubic_resampler.sv]
// Top level of the four-point Lagrange resampler: configuration register port,
// controller and datapath. Depends on lcr_pkg, lcr_stream_if, lcr_ctrl, lcr_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The resampler takes one 16-bit source sample per input request and emits
// the output samples that lie at positions j*rate_step of the current clip,
// where rate_step is an unsigned fixed-point value with FRAC_BITS fraction
// bits written through the register port at byte address 0. Each output is a
// cubic Lagrange interpolation over the four samples around its position, or
// a linear one between two neighbors near the start and the end of a clip,
// truncated toward zero and saturated to 16 bits. The result that closes an
// input request carries last_of_run, and on a request that ends the clip it
// also carries clip_done; a request with clip_end restarts the position at
// zero. One input request yields at most MAX_OUT_PER_IN results. The block
// works on one input request at a time, with a single shared multiplier for
// the Horner steps: a request is accepted in the idle state, each cubic
// output steps through setup, MUL_A, MUL_H, MUL_G, scale, reciprocal and
// final, each linear output through setup, MUL_A, scale and final, and a
// closing check ends the request. A finished result waits while the output
// register is still held by the previous one. The output register lets a
// new request be accepted while the last result of the previous one waits
// to be taken. Change rate_step only while no request is in progress.
module lagrange_cubic_resampler #(
    parameter int FRAC_BITS      = lcr_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS     = lcr_pkg::INDEX_BITS_DEF,
    parameter int MAX_OUT_PER_IN = lcr_pkg::MAX_OUT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    lcr_in_if.sink                           i_in,
    lcr_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lcr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [lcr_pkg::APB_DW-1:0]  pwdata,
    output logic [lcr_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    localparam int STEP_W = lcr_pkg::STEP_W;

    logic [STEP_W-1:0]           r_rate_step;
    logic [lcr_pkg::APB_AW-3:0]  reg_sel;
    logic                        reg_hit;
    logic                        rate_wr;
    lcr_pkg::t_dp_cmd            dp_cmd;
    lcr_pkg::t_dp_status         dp_status;

    // Register port: a single word-aligned register, written in the access
    // phase. Reads of unmapped words return zero.
    assign pready  = 1'b1;
    assign reg_sel = paddr[lcr_pkg::APB_AW-1:2];
    assign reg_hit = (reg_sel == lcr_pkg::REG_RATE_STEP);
    assign rate_wr = psel && penable && pwrite && reg_hit;
    assign prdata  = reg_hit ? {{(lcr_pkg::APB_DW-STEP_W){1'b0}}, r_rate_step} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_step <= lcr_pkg::RATE_STEP_RST;
        end else if (rate_wr) begin
            r_rate_step <= pwdata[STEP_W-1:0];
        end
    end

    lcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    lcr_datapath #(
        .FRAC_BITS      (FRAC_BITS),
        .INDEX_BITS     (INDEX_BITS),
        .MAX_OUT_PER_IN (MAX_OUT_PER_IN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_rate_step   (r_rate_step),
        .i_sample_in   (i_in.sample_in),
        .i_clip_end    (i_in.clip_end),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_sample_out  (o_out.sample_out),
        .o_last_of_run (o_out.last_of_run),
        .o_clip_done   (o_out.clip_done)
    );

    // Only one request is in work at a time, so acceptance drops ready.
    a_one_in_flight: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready
    ) else $error("input accepted on two consecutive cycles");

    // The end of a clip is always marked on the result that closes a request.
    a_done_is_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.clip_done || o_out.last_of_run)
    ) else $error("clip_done without last_of_run");

    // A write to the rate register takes effect at the access edge.
    a_rate_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        rate_wr |=> (r_rate_step == $past(pwdata[STEP_W-1:0]))
    ) else $error("rate_step write lost");

endmodule

`default_nettype wire
